@@ hdl/assert_macros.svh @@
// Assertion helper macros for the tilt leveling design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion on clk with reset disable.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication shorthand.
`define ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`endif

@@ hdl/tlsm_pkg.sv @@
// ---------------------------------------------------------------------------
// tlsm_pkg
// Shared types and constants of the tilt leveling servo mixer.
// ---------------------------------------------------------------------------
`default_nettype none
package tlsm_pkg;
    localparam int ACC_FRAC  = 16;
    localparam int TABLE_LEN = 24;
    localparam int ZW        = 26;
    localparam int CW        = 40;

    localparam logic [2:0] REG_PITCH_GAIN = 3'd0;
    localparam logic [2:0] REG_ROLL_GAIN  = 3'd1;
    localparam logic [2:0] REG_CENTER     = 3'd2;
    localparam logic [2:0] REG_MIN        = 3'd3;
    localparam logic [2:0] REG_MAX        = 3'd4;

    typedef struct packed {
        logic [11:0] pitch_gain;
        logic [11:0] roll_gain;
        logic [7:0]  center_angle;
        logic [7:0]  min_angle;
        logic [7:0]  max_angle;
    } cfg_t;

    // Item handed from the front to the back over the queue.
    typedef struct packed {
        logic signed [16:0] ax;
        logic [16:0]        rp;
        logic signed [16:0] ay;
        logic [16:0]        rq;
    } vec_t;

    function automatic logic signed [ZW-1:0] atan_q16(input int i);
        logic signed [ZW-1:0] t;
        begin
            unique case (i)
                0: t = 26'sd2949120;  1: t = 26'sd1740967;  2: t = 26'sd919879;
                3: t = 26'sd466945;   4: t = 26'sd234379;   5: t = 26'sd117304;
                6: t = 26'sd58666;    7: t = 26'sd29335;    8: t = 26'sd14668;
                9: t = 26'sd7334;     10: t = 26'sd3667;    11: t = 26'sd1833;
                12: t = 26'sd917;     13: t = 26'sd458;     14: t = 26'sd229;
                15: t = 26'sd115;     16: t = 26'sd57;      17: t = 26'sd29;
                18: t = 26'sd14;      19: t = 26'sd7;       20: t = 26'sd4;
                21: t = 26'sd2;       22: t = 26'sd1;
                default: t = '0;
            endcase
            return t;
        end
    endfunction
endpackage
`default_nettype wire

@@ hdl/tilt_leveling_servo_mixer.sv @@
// ---------------------------------------------------------------------------
// tilt_leveling_servo_mixer
// Accelerometer tilt to four corner servo angles.
// ---------------------------------------------------------------------------
// Each item is one accelerometer sample and gives one result. The front takes
// the squares and two floor square roots in a 18 stage pipeline, a four entry
// queue follows, and the back runs two CORDIC pipelines of CORDIC_STEPS stages
// (at most TABLE_LEN) behind a load stage, plus four mixing stages. A new item
// is taken every cycle unless the output stalls. Configuration takes effect on
// items in flight.
`default_nettype none
module tilt_leveling_servo_mixer
    import tlsm_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int CORDIC_STEPS    = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [11:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // accel_x, accel_y, accel_z
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // front_left, front_right, back_left, back_right, pitch_degrees, roll_degrees
    output logic [63:0]      m_axis_tdata
);
    `include "assert_macros.svh"

    cfg_t cfg_reg;
    vec_t f_vec, q_vec;
    logic f_valid, f_ready, q_valid, q_ready;
    logic [7:0]  fl, fr, bl, br;
    logic [15:0] pitch, roll;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{pitch_gain: 12'd256, roll_gain: 12'd256, center_angle: 8'd90,
                         min_angle: 8'd45, max_angle: 8'd135};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PITCH_GAIN: cfg_reg.pitch_gain   <= cfg_data;
                REG_ROLL_GAIN:  cfg_reg.roll_gain    <= cfg_data;
                REG_CENTER:     cfg_reg.center_angle <= cfg_data[7:0];
                REG_MIN:        cfg_reg.min_angle    <= cfg_data[7:0];
                REG_MAX:        cfg_reg.max_angle    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    tlsm_front u_front (
        .clk, .rst_n,
        .in_valid (s_axis_tvalid), .in_ready (s_axis_tready),
        .ax (s_axis_tdata[15:0]), .ay (s_axis_tdata[31:16]), .az (s_axis_tdata[47:32]),
        .out_valid (f_valid), .out_ready (f_ready), .out_vec (f_vec)
    );

    tlsm_queue u_queue (
        .clk, .rst_n,
        .in_valid (f_valid), .in_ready (f_ready), .in_vec (f_vec),
        .out_valid (q_valid), .out_ready (q_ready), .out_vec (q_vec)
    );

    tlsm_back #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .clk, .rst_n, .cfg (cfg_reg),
        .in_valid (q_valid), .in_ready (q_ready), .in_vec (q_vec),
        .out_valid (m_axis_tvalid), .out_ready (m_axis_tready),
        .fl, .fr, .bl, .br, .pitch, .roll
    );

    assign m_axis_tdata = {roll, pitch, br, bl, fr, fl};

    `ASSERT_IMP(a_front_hold, f_valid && !f_ready, ##1 f_valid, "front item lost")
    `ASSERT_IMP(a_out_hold, m_axis_tvalid && !m_axis_tready,
                ##1 (m_axis_tvalid && $stable(m_axis_tdata)), "result changed while stalled")
    `ASSERT_CLK(a_clamp_lo, !m_axis_tvalid || cfg_reg.min_angle > cfg_reg.max_angle ||
                m_axis_tdata[7:0] >= cfg_reg.min_angle || cfg_we, "angle below min")
endmodule
`default_nettype wire

@@ hdl/tlsm_front.sv @@
// ---------------------------------------------------------------------------
// tlsm_front
// Squares the axes and takes the two floor roots, one digit pair per stage.
// ---------------------------------------------------------------------------
`default_nettype none
module tlsm_front
    import tlsm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] ax,
    input  wire logic [15:0] ay,
    input  wire logic [15:0] az,
    output logic             out_valid,
    input  wire logic        out_ready,
    output vec_t             out_vec
);
    localparam int RS = 16;   // one result bit per stage

    logic                v_reg [0:RS+1];
    logic signed [16:0]  x_reg [0:RS+1];
    logic signed [16:0]  y_reg [0:RS+1];
    logic [32:0]         sp_reg [0:RS+1];
    logic [32:0]         sq_reg [0:RS+1];
    logic [16:0]         rp_reg [0:RS+1];
    logic [16:0]         rq_reg [0:RS+1];
    logic [32:0]         ep_reg [0:RS+1];
    logic [32:0]         eq_reg [0:RS+1];
    logic                adv;
    logic signed [32:0]  sx, sy, sz;

    assign adv      = !v_reg[RS+1] || out_ready;
    assign in_ready = adv;
    assign out_valid = v_reg[RS+1];
    assign out_vec  = '{ax: x_reg[RS+1], rp: rp_reg[RS+1],
                        ay: y_reg[RS+1], rq: rq_reg[RS+1]};

    // The axes are widened before squaring so the products keep all their bits.
    assign sx = 33'(signed'(ax));
    assign sy = 33'(signed'(ay));
    assign sz = 33'(signed'(az));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= RS+1; k++) v_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= RS+1; k++) v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Stage 0: squares.
            x_reg[0]  <= 17'(signed'(ax));
            y_reg[0]  <= 17'(signed'(ay));
            sp_reg[0] <= sy * sy + sz * sz;
            sq_reg[0] <= sx * sx + sz * sz;
            rp_reg[0] <= '0;
            rq_reg[0] <= '0;
            // Stage 1: root setup.
            x_reg[1]  <= x_reg[0];
            y_reg[1]  <= y_reg[0];
            ep_reg[1] <= sp_reg[0];
            eq_reg[1] <= sq_reg[0];
            rp_reg[1] <= '0;
            rq_reg[1] <= '0;
            // Restoring root stages, one bit each from the top.
            for (int k = 2; k <= RS+1; k++)
            begin
                logic [34:0] tp;
                logic [34:0] tq;
                int          b;
                b  = RS + 1 - k;
                tp = 35'({rp_reg[k-1], 1'b0, 1'b1}) << (2 * b);
                tq = 35'({rq_reg[k-1], 1'b0, 1'b1}) << (2 * b);
                x_reg[k] <= x_reg[k-1];
                y_reg[k] <= y_reg[k-1];
                if (35'(ep_reg[k-1]) >= tp)
                begin
                    ep_reg[k] <= 33'(35'(ep_reg[k-1]) - tp);
                    rp_reg[k] <= {rp_reg[k-1][15:0], 1'b1};
                end
                else
                begin
                    ep_reg[k] <= ep_reg[k-1];
                    rp_reg[k] <= {rp_reg[k-1][15:0], 1'b0};
                end
                if (35'(eq_reg[k-1]) >= tq)
                begin
                    eq_reg[k] <= 33'(35'(eq_reg[k-1]) - tq);
                    rq_reg[k] <= {rq_reg[k-1][15:0], 1'b1};
                end
                else
                begin
                    eq_reg[k] <= eq_reg[k-1];
                    rq_reg[k] <= {rq_reg[k-1][15:0], 1'b0};
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ hdl/tlsm_queue.sv @@
// ---------------------------------------------------------------------------
// tlsm_queue
// Short queue between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none
module tlsm_queue
    import tlsm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire vec_t in_vec,
    output logic      out_valid,
    input  wire logic out_ready,
    output vec_t      out_vec
);
    vec_t       mem_reg [0:3];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       wr, rd;

    assign in_ready  = cnt_reg != 3'd4;
    assign out_valid = cnt_reg != 3'd0;
    assign out_vec   = mem_reg[rp_reg];
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= in_vec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= wp_reg + 2'd1;
            if (rd) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(wr) - 3'(rd);
        end
    end
endmodule
`default_nettype wire

@@ hdl/tlsm_back.sv @@
// ---------------------------------------------------------------------------
// tlsm_back
// Pipelined CORDIC for both angles, then the gain mix and clamps.
// ---------------------------------------------------------------------------
`default_nettype none
module tlsm_back
    import tlsm_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int CORDIC_STEPS    = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire vec_t        in_vec,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       fl,
    output logic [7:0]       fr,
    output logic [7:0]       bl,
    output logic [7:0]       br,
    output logic [15:0]      pitch,
    output logic [15:0]      roll
);
    localparam int N   = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int SH  = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int D   = N + 4;
    localparam int PW  = 36;

    logic                 v_reg [0:D];
    logic signed [CW-1:0] px_reg [0:N], py_reg [0:N], qx_reg [0:N], qy_reg [0:N];
    logic signed [ZW-1:0] pz_reg [0:N], qz_reg [0:N];
    logic                 pzero_reg [0:N], qzero_reg [0:N];
    logic signed [15:0]   pa_reg, qa_reg;
    logic signed [PW-1:0] mp_reg, mq_reg;
    logic signed [PW-1:0] s_reg [0:3];
    logic signed [15:0]   pb_reg, qb_reg, pc_reg, qc_reg;
    logic [7:0]           ang_reg [0:3];
    logic [15:0]          po_reg, qo_reg;
    logic                 adv;

    assign adv       = !v_reg[D] || out_ready;
    assign in_ready  = adv;
    assign out_valid = v_reg[D];
    assign fl = ang_reg[0];
    assign fr = ang_reg[1];
    assign bl = ang_reg[2];
    assign br = ang_reg[3];
    assign pitch = po_reg;
    assign roll  = qo_reg;

    function automatic logic signed [15:0] finish(input logic signed [ZW-1:0] z,
                                                  input logic zero);
        logic signed [ZW+1:0] c;
        logic signed [ZW+1:0] r;
        logic signed [ZW+1:0] lim;
        begin
            lim = (ZW+2)'(90) <<< ACC_FRAC;
            c = (ZW+2)'(z);
            if (c > lim) c = lim;
            if (c < -lim) c = -lim;
            if (SH > 0) r = (c + ((ZW+2)'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
            else r = c <<< (-SH);
            if (zero) r = '0;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return 16'(r);
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= D; k++) v_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= D; k++) v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg[0] <= CW'(signed'({1'b0, in_vec.rp})) <<< 16;
            py_reg[0] <= CW'(in_vec.ax) <<< 16;
            qx_reg[0] <= CW'(signed'({1'b0, in_vec.rq})) <<< 16;
            qy_reg[0] <= CW'(in_vec.ay) <<< 16;
            pz_reg[0] <= '0;
            qz_reg[0] <= '0;
            pzero_reg[0] <= (in_vec.ax == '0) && (in_vec.rp == '0);
            qzero_reg[0] <= (in_vec.ay == '0) && (in_vec.rq == '0);
            for (int i = 0; i < N; i++)
            begin
                pzero_reg[i+1] <= pzero_reg[i];
                qzero_reg[i+1] <= qzero_reg[i];
                if (!py_reg[i][CW-1])
                begin
                    px_reg[i+1] <= px_reg[i] + (py_reg[i] >>> i);
                    py_reg[i+1] <= py_reg[i] - (px_reg[i] >>> i);
                    pz_reg[i+1] <= pz_reg[i] + atan_q16(i);
                end
                else
                begin
                    px_reg[i+1] <= px_reg[i] - (py_reg[i] >>> i);
                    py_reg[i+1] <= py_reg[i] + (px_reg[i] >>> i);
                    pz_reg[i+1] <= pz_reg[i] - atan_q16(i);
                end
                if (!qy_reg[i][CW-1])
                begin
                    qx_reg[i+1] <= qx_reg[i] + (qy_reg[i] >>> i);
                    qy_reg[i+1] <= qy_reg[i] - (qx_reg[i] >>> i);
                    qz_reg[i+1] <= qz_reg[i] + atan_q16(i);
                end
                else
                begin
                    qx_reg[i+1] <= qx_reg[i] - (qy_reg[i] >>> i);
                    qy_reg[i+1] <= qy_reg[i] + (qx_reg[i] >>> i);
                    qz_reg[i+1] <= qz_reg[i] - atan_q16(i);
                end
            end
            // Output scaling of both angles.
            pa_reg <= finish(pz_reg[N], pzero_reg[N]);
            qa_reg <= finish(qz_reg[N], qzero_reg[N]);
            // Gain products.
            mp_reg <= PW'(pa_reg) * PW'($signed({1'b0, cfg.pitch_gain}));
            mq_reg <= PW'(qa_reg) * PW'($signed({1'b0, cfg.roll_gain}));
            pb_reg <= pa_reg;
            qb_reg <= qa_reg;
            // Corner sums with signs (-,-), (-,+), (+,-), (+,+).
            s_reg[0] <= -mp_reg - mq_reg;
            s_reg[1] <= -mp_reg + mq_reg;
            s_reg[2] <= mp_reg - mq_reg;
            s_reg[3] <= mp_reg + mq_reg;
            pc_reg <= pb_reg;
            qc_reg <= qb_reg;
            // Truncate toward zero, add center, clamp.
            for (int c = 0; c < 4; c++)
            begin
                logic [PW-1:0]        m;
                logic signed [PW-1:0] t;
                logic signed [PW-1:0] a;
                m = s_reg[c][PW-1] ? PW'(-s_reg[c]) : PW'(s_reg[c]);
                t = $signed(m >> (ANGLE_FRAC_BITS + 8));
                if (s_reg[c][PW-1]) t = -t;
                a = PW'(cfg.center_angle) + t;
                if (a < $signed(PW'(cfg.min_angle))) ang_reg[c] <= cfg.min_angle;
                else if (a > $signed(PW'(cfg.max_angle))) ang_reg[c] <= cfg.max_angle;
                else ang_reg[c] <= a[7:0];
            end
            po_reg <= pc_reg;
            qo_reg <= qc_reg;
        end
    end
endmodule
`default_nettype wire

@@ verif/tilt_servo_checker.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tilt_servo_checker
// Watches the sample and result streams of the tilt leveling servo mixer,
// predicts every result from its own copy of the registers and compares the
// results field by field, in order.
// ---------------------------------------------------------------------------
module tilt_servo_checker
    import tlsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // accel_x, accel_y, accel_z
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // front_left, front_right, back_left, back_right, pitch_degrees, roll_degrees
    input  logic [63:0] m_axis_tdata,
    output int          fail_count,
    output int          pending,
    output int          result_count
);
    // Arctangent of 2^-i in degrees with 16 fraction bits.
    localparam longint ATAN_DEG [16] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    logic [11:0] pitch_gain;
    logic [11:0] roll_gain;
    logic [7:0]  center_angle;
    logic [7:0]  min_angle;
    logic [7:0]  max_angle;
    logic [63:0] angle_queue[$];

    function automatic longint floor_root(longint v);
        longint res;
        longint bits;
        res = 0;
        bits = 64'd1 << 30;
        while (bits > v)
            bits = bits >> 2;
        while (bits != 0)
        begin
            if (v >= res + bits)
            begin
                v = v - (res + bits);
                res = (res >> 1) + bits;
            end
            else
                res = res >> 1;
            bits = bits >> 2;
        end
        return res;
    endfunction

    // Vectoring CORDIC giving atan2(a, r) in degrees, Q8.8.
    function automatic longint tilt_angle(longint a, longint r);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint lim;
        z = 0;
        lim = 64'sd90 <<< 16;
        if (a == 0 && r == 0)
            return 0;
        x = r * 65536;
        y = a * 65536;
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_DEG[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_DEG[i];
            end
        end
        if (z > lim)
            z = lim;
        if (z < -lim)
            z = -lim;
        z = (z + 128) >>> 8;
        if (z > 32767)
            z = 32767;
        if (z < -32768)
            z = -32768;
        return z;
    endfunction

    function automatic logic [7:0] corner_angle(longint p, longint q, longint sp, longint sq);
        longint s;
        longint t;
        longint ang;
        s = sp * p * longint'(pitch_gain) + sq * q * longint'(roll_gain);
        t = ((s < 0) ? -s : s) >> 16;
        if (s < 0)
            t = -t;
        ang = longint'(center_angle) + t;
        if (ang < longint'(min_angle))
            ang = min_angle;
        else if (ang > longint'(max_angle))
            ang = max_angle;
        return ang[7:0];
    endfunction

    function automatic logic [63:0] servo_mix(logic [47:0] sample);
        longint ax;
        longint ay;
        longint az;
        longint p;
        longint q;
        logic [15:0] p16;
        logic [15:0] q16;
        ax = longint'($signed(sample[15:0]));
        ay = longint'($signed(sample[31:16]));
        az = longint'($signed(sample[47:32]));
        p = tilt_angle(ax, floor_root(ay * ay + az * az));
        q = tilt_angle(ay, floor_root(ax * ax + az * az));
        p16 = p[15:0];
        q16 = q[15:0];
        return {q16, p16, corner_angle(p, q, 1, 1), corner_angle(p, q, 1, -1),
                corner_angle(p, q, -1, 1), corner_angle(p, q, -1, -1)};
    endfunction

    task automatic check_field(string name, longint expected_v, longint actual_v);
        if (expected_v != actual_v)
        begin
            $error("%s: expected %0d, got %0d", name, expected_v, actual_v);
            fail_count++;
        end
    endtask

    assign pending = angle_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [63:0] exp_r;
        if (!rst_n)
        begin
            pitch_gain   <= 12'd256;
            roll_gain    <= 12'd256;
            center_angle <= 8'd90;
            min_angle    <= 8'd45;
            max_angle    <= 8'd135;
            fail_count   = 0;
            result_count = 0;
            angle_queue.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                result_count++;
                if (angle_queue.size() == 0)
                begin
                    $error("result with no sample waiting: %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    exp_r = angle_queue.pop_front();
                    check_field("front_left_angle", exp_r[7:0], m_axis_tdata[7:0]);
                    check_field("front_right_angle", exp_r[15:8], m_axis_tdata[15:8]);
                    check_field("back_left_angle", exp_r[23:16], m_axis_tdata[23:16]);
                    check_field("back_right_angle", exp_r[31:24], m_axis_tdata[31:24]);
                    check_field("pitch_degrees", $signed(exp_r[47:32]),
                                $signed(m_axis_tdata[47:32]));
                    check_field("roll_degrees", $signed(exp_r[63:48]),
                                $signed(m_axis_tdata[63:48]));
                end
            end
            // Prediction uses the registers as they stood before this edge.
            if (s_axis_tvalid && s_axis_tready)
                angle_queue.push_back(servo_mix(s_axis_tdata));
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PITCH_GAIN: pitch_gain   <= cfg_data;
                    REG_ROLL_GAIN:  roll_gain    <= cfg_data;
                    REG_CENTER:     center_angle <= cfg_data[7:0];
                    REG_MIN:        min_angle    <= cfg_data[7:0];
                    REG_MAX:        max_angle    <= cfg_data[7:0];
                    default:        ;
                endcase
            end
        end
    end
endmodule

@@ verif/tb_tilt_leveling_servo_mixer.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_tilt_leveling_servo_mixer
// Drives samples and register settings into the servo mixer and gives the
// verdict from the checker's failure count.
// ---------------------------------------------------------------------------
module tb_tilt_leveling_servo_mixer;
    import tlsm_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = REG_PITCH_GAIN;
    logic [11:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    int          fail_count;
    int          pending;
    int          result_count;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          setting_count = 0;

    always #5 clk = ~clk;

    tilt_leveling_servo_mixer uut (.*);

    tilt_servo_checker checker_i (.*);

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        logic rdy;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        do
        begin
            @(negedge clk);
            rdy = s_axis_tready;
            @(posedge clk);
        end
        while (!rdy);
    endtask

    // Waits for every expected result, then for the pipeline to settle.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_regs(logic [11:0] pg, logic [11:0] rg, logic [7:0] ctr,
                            logic [7:0] lo, logic [7:0] hi);
        logic [11:0] vals [5];
        vals = '{pg, rg, {4'd0, ctr}, {4'd0, lo}, {4'd0, hi}};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        // Unused index: the write must change nothing.
        cfg_index <= 3'($urandom_range(7, 5));
        cfg_data  <= 12'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        setting_count++;
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'($signed($urandom_range(8)) - 4);
            2:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            3, 4:    return 16'($signed($urandom_range(4000)) - 2000);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_run(int count);
        for (int i = 0; i < count; i++)
            send_sample(rand_axis(), rand_axis(), rand_axis());
    endtask

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings: zero vector, axis extremes, single bits.
        send_sample(16'd0, 16'd0, 16'd0);
        send_sample(16'h7FFF, 16'd0, 16'd0);
        send_sample(16'h8000, 16'd0, 16'd0);
        send_sample(16'd0, 16'h7FFF, 16'd0);
        send_sample(16'd0, 16'h8000, 16'd0);
        send_sample(16'd0, 16'd0, 16'h7FFF);
        send_sample(16'd0, 16'd0, 16'h8000);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h7FFF, 16'h8000, 16'd0);
        send_sample(16'd1, 16'd0, 16'd0);
        send_sample(16'hFFFF, 16'd1, 16'd0);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(16'd100, 16'hFF9C, 16'd16384);
        drain();

        // Largest gains and full servo span: corrections saturate.
        set_regs(12'd4095, 12'd4095, 8'd180, 8'd0, 8'd180);
        send_sample(16'h7FFF, 16'd0, 16'd0);
        send_sample(16'h8000, 16'h7FFF, 16'd0);
        send_sample(16'd3000, 16'hF000, 16'd16000);
        send_sample(16'd0, 16'd0, 16'd0);
        drain();

        // Minimum above maximum: every corner angle is one of the two limits.
        set_regs(12'd300, 12'd700, 8'd90, 8'd120, 8'd60);
        send_sample(16'd0, 16'd0, 16'd16384);
        send_sample(16'd5000, 16'hE000, 16'd9000);
        send_sample(16'h8000, 16'h8000, 16'd0);
        drain();

        // Zero gains with register values above 180.
        set_regs(12'd0, 12'd0, 8'd255, 8'd0, 8'd255);
        send_sample(16'h7FFF, 16'h8000, 16'd1);
        send_sample(16'd0, 16'd0, 16'd0);
        drain();

        set_regs(12'd256, 12'd256, 8'd90, 8'd45, 8'd135);
        send_idle_pct = 32;
        recv_idle_pct = 81;
        random_run(360);
        drain();

        set_regs(12'($urandom), 12'($urandom), 8'($urandom_range(180)),
                 8'($urandom_range(60)), 8'($urandom_range(180, 120)));
        send_idle_pct = 81;
        recv_idle_pct = 32;
        random_run(360);
        drain();

        set_regs(12'($urandom_range(1024)), 12'($urandom_range(4095, 2048)), 8'd0,
                 8'd0, 8'd180);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_run(180);
        drain();
        set_regs(12'($urandom), 12'($urandom), 8'($urandom),
                 8'($urandom), 8'($urandom));
        random_run(180);
        drain();

        $display("Covered %0d results over %0d register settings, with sender and",
                 result_count, setting_count);
        $display("receiver stalls in both proportions and at full rate.");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
